@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros for the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, disabled while reset is asserted
`define ASSERT_CLKD(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// concurrent check that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

@@ rtl/core/lbc_pkg.sv @@
// ----------------------------------------------------------------------------
// lbc_pkg
// shared types and constants of the (16,8) systematic block codec
// ----------------------------------------------------------------------------
package lbc_pkg;

  localparam int ROWS      = 8;
  localparam int DATA_W    = 8;
  localparam int WORD_W    = 16;
  localparam int CFG_IDX_W = 4;

  // operation codes
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // status codes
  localparam logic [1:0] ST_CLEAN    = 2'd0;
  localparam logic [1:0] ST_FLIPPED  = 2'd1;
  localparam logic [1:0] ST_NO_MATCH = 2'd2;

  typedef logic [ROWS-1:0][DATA_W-1:0] row_masks_t;

  // reset contents of the check-row masks, row 0 in the low slot
  localparam row_masks_t ROW_MASK_RESET = {
    8'd1, 8'd9, 8'd41, 8'd169, 8'd171, 8'd187, 8'd251, 8'd255
  };

  typedef struct packed {
    logic [WORD_W-1:0] word_out;
    logic [DATA_W-1:0] data_out;
    logic [ROWS-1:0]   syndrome;
    logic [1:0]        status;
  } lbc_result_t;

endpackage

@@ rtl/core/lbc_ifs.sv @@
// ----------------------------------------------------------------------------
// lbc_ifs
// valid/ready channels of the block codec: input, result and configuration
// ----------------------------------------------------------------------------
interface lbc_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] word_in;

  modport source (output valid, output op, output word_in, input ready);
  modport sink (input valid, input op, input word_in, output ready);
endinterface

interface lbc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] word_out;
  logic [7:0]  data_out;
  logic [7:0]  syndrome;
  logic [1:0]  status;

  modport source (output valid, output word_out, output data_out, output syndrome,
                  output status, input ready);
  modport sink (input valid, input word_out, input data_out, input syndrome,
                input status, output ready);
endinterface

interface lbc_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] index;
  logic [7:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

@@ rtl/core/lbc_codec_core.sv @@
// ----------------------------------------------------------------------------
// lbc_codec_core
// parity / syndrome xor trees and column match for one codeword
// ----------------------------------------------------------------------------
module lbc_codec_core (
  input  logic                op,
  input  logic [15:0]         word,
  input  lbc_pkg::row_masks_t masks,
  output lbc_pkg::lbc_result_t res
);
  import lbc_pkg::*;

  logic [ROWS-1:0]   parity;
  logic [ROWS-1:0]   syn;
  logic [WORD_W-1:0] flips;
  logic [ROWS-1:0]   col;

  // parity bit r: xor over data bits covered by row r
  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      parity[r] = ^(word[DATA_W-1:0] & masks[r]);
    end
  end

  assign syn = (op == OP_DECODE) ? (parity ^ word[WORD_W-1:DATA_W]) : '0;

  // a bit flips when its matrix column equals the syndrome
  always_comb begin
    flips = '0;
    col   = '0;
    for (int i = 0; i < DATA_W; i++) begin
      for (int r = 0; r < ROWS; r++) begin
        col[r] = masks[r][i];
      end
      flips[i] = (syn != '0) && (col == syn);
    end
    for (int i = 0; i < ROWS; i++) begin
      flips[DATA_W+i] = (syn == (ROWS'(1) << i));
    end
  end

  always_comb begin
    if (op == OP_ENCODE) begin
      res.word_out = {parity, word[DATA_W-1:0]};
      res.status   = ST_CLEAN;
    end else begin
      res.word_out = word ^ flips;
      if (syn == '0) begin
        res.status = ST_CLEAN;
      end else if (flips != '0) begin
        res.status = ST_FLIPPED;
      end else begin
        res.status = ST_NO_MATCH;
      end
    end
    res.data_out = res.word_out[DATA_W-1:0];
    res.syndrome = syn;
  end

endmodule

@@ rtl/core/linear_block_codec_16_8.sv @@
// ----------------------------------------------------------------------------
// linear_block_codec_16_8: systematic (16,8) encoder and syndrome corrector
// path: an accepted item is captured in the input register, then in the result
// register, where it is offered (input reg, result reg)
// throughput: one item per cycle unless results stall; one xor/compare stage
// reset: rst_n synchronous active low, empties both stages, masks to defaults
// ----------------------------------------------------------------------------
module linear_block_codec_16_8 (
  input  logic      clk,
  input  logic      rst_n,
  lbc_in_if.sink    in_ch,
  lbc_out_if.source out_ch,
  lbc_cfg_if.sink   cfg_ch
);
  import lbc_pkg::*;

  // check-row mask registers, written through the config channel
  row_masks_t  masks_r;
  row_masks_t  masks_nxt;

  // input stage
  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic        s1_op_r;
  logic [15:0] s1_word_r;

  // result stage
  logic        out_valid_r;
  logic        out_valid_nxt;
  lbc_result_t out_res_r;
  lbc_result_t core_res;

  // pipeline flow control
  logic        out_adv;
  logic        s1_adv;

  // config writes are always taken; out-of-range indexes drop silently
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    masks_nxt = masks_r;
    if (cfg_ch.valid && (cfg_ch.index < CFG_IDX_W'(ROWS))) begin
      masks_nxt[cfg_ch.index[2:0]] = cfg_ch.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      masks_r <= ROW_MASK_RESET;
    end else begin
      masks_r <= masks_nxt;
    end
  end

  // result register moves when empty or taken; input stage moves when empty
  // or its item moves on, so a waiting result blocks intake once it is full
  assign out_adv     = !out_valid_r || out_ch.ready;
  assign s1_adv      = !s1_valid_r || out_adv;
  assign in_ch.ready = s1_adv;

  assign s1_valid_nxt  = s1_adv ? in_ch.valid : s1_valid_r;
  assign out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input payload capture
  always_ff @(posedge clk) begin
    if (s1_adv && in_ch.valid) begin
      s1_op_r   <= in_ch.op;
      s1_word_r <= in_ch.word_in;
    end
  end

  // encode / syndrome / correction logic
  lbc_codec_core u_core (
    .op    (s1_op_r),
    .word  (s1_word_r),
    .masks (masks_r),
    .res   (core_res)
  );

  // result payload capture
  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_res_r <= core_res;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.word_out = out_res_r.word_out;
  assign out_ch.data_out = out_res_r.data_out;
  assign out_ch.syndrome = out_res_r.syndrome;
  assign out_ch.status   = out_res_r.status;

endmodule

@@ rtl/core/lbc_checker.sv @@
// ----------------------------------------------------------------------------
// lbc_checker
// port-level checks of the block codec, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lbc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] word_out,
  input logic [7:0]  data_out,
  input logic [1:0]  status
);
  import lbc_pkg::*;

  // a stalled result stays offered and unchanged
  `ASSERT_CLKD(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid)
  `ASSERT_CLKD(a_out_stable, clk, rst_n, (out_valid && !out_ready) |=> $stable(word_out))

  // data byte mirrors the low byte of the word, status is a legal code
  `ASSERT_CLKD(a_data_low, clk, rst_n, out_valid |-> (data_out == word_out[7:0]))
  `ASSERT_CLKD(a_status_ok, clk, rst_n,
    out_valid |-> (status == ST_CLEAN || status == ST_FLIPPED || status == ST_NO_MATCH))

  // nothing is offered right after reset
  `ASSERT_ALWAYS(a_rst_empty, clk, (rst_n && !$past(rst_n)) |-> !out_valid)

endmodule

bind linear_block_codec_16_8 lbc_checker u_lbc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .word_out  (out_ch.word_out),
  .data_out  (out_ch.data_out),
  .status    (out_ch.status)
);

@@ tb/sv/linear_block_codec_16_8_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_block_codec_16_8_test
// directed and random check of the (16,8) encoder and syndrome corrector:
// items go in and results come out under random stalls, the check-row masks
// are reloaded between phases, and every result is compared with a local model
// ----------------------------------------------------------------------------
module linear_block_codec_16_8_test;
  import lbc_pkg::*;

  // cycles with no handshake on any channel before the run is declared hung
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic              op;
    logic [WORD_W-1:0] word;
  } codec_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #4 clk = ~clk;

  lbc_in_if  in_ch ();
  lbc_out_if out_ch ();
  lbc_cfg_if cfg_ch ();

  linear_block_codec_16_8 uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // local copy of the check-row masks, follows every accepted register write
  row_masks_t  check_rows;
  // items waiting to be driven, and results owed by the block in order
  codec_item_t queued_words[$];
  lbc_result_t awaited_results[$];
  int          error_count = 0;
  // set for the stretch where neither side stalls
  bit          no_stall = 1'b0;
  int          stall_cycles = 0;

  // encode a byte, or compute the syndrome of a codeword and flip every bit
  // whose column of [A | I8] equals it
  function automatic lbc_result_t coded_result(logic op, logic [WORD_W-1:0] word);
    lbc_result_t       res;
    logic [ROWS-1:0]   parity;
    logic [ROWS-1:0]   column;
    logic [WORD_W-1:0] flips;
    int                r;
    int                i;
    res = '0;
    flips = '0;
    for (r = 0; r < ROWS; r++)
      parity[r] = ^(word[DATA_W-1:0] & check_rows[r]);
    if (op == OP_ENCODE) begin
      // high byte of the input is ignored on encode
      res.word_out = {parity, word[DATA_W-1:0]};
      res.status   = ST_CLEAN;
    end else begin
      res.syndrome = parity ^ word[WORD_W-1:DATA_W];
      res.status   = ST_CLEAN;
      // zero syndrome: no flips, even where a data column is all zero
      if (res.syndrome != '0) begin
        for (i = 0; i < WORD_W; i++) begin
          if (i < DATA_W) begin
            for (r = 0; r < ROWS; r++)
              column[r] = check_rows[r][i];
          end else begin
            column = 8'h01 << (i - DATA_W);
          end
          // equal columns all flip, so several bits may change
          if (column == res.syndrome)
            flips[i] = 1'b1;
        end
        res.status = (flips != '0) ? ST_FLIPPED : ST_NO_MATCH;
      end
      res.word_out = word ^ flips;
    end
    res.data_out = res.word_out[DATA_W-1:0];
    return res;
  endfunction

  function automatic logic [WORD_W-1:0] codeword_of(logic [DATA_W-1:0] data);
    return coded_result(OP_ENCODE, {8'h00, data}).word_out;
  endfunction

  task automatic add_item(logic op, logic [WORD_W-1:0] word);
    queued_words.insert(queued_words.size(), codec_item_t'{op: op, word: word});
  endtask

  // half valid codewords with zero to two bit errors, the rest encodes and noise
  task automatic add_random_items(int count);
    int                pick;
    int                nerr;
    logic [WORD_W-1:0] word;
    repeat (count) begin
      pick = $urandom_range(99);
      word = WORD_W'($urandom);
      if (pick < 25) begin
        add_item(OP_ENCODE, word);
      end else if (pick < 75) begin
        word = codeword_of(word[DATA_W-1:0]);
        nerr = $urandom_range(2);
        repeat (nerr) word ^= 16'h0001 << $urandom_range(WORD_W - 1);
        add_item(OP_DECODE, word);
      end else begin
        add_item(OP_DECODE, word);
      end
    end
  endtask

  // returns once every queued item has gone in and every result has come out
  task automatic wait_idle;
    while (queued_words.size() != 0 || in_ch.valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // called at a rising edge; leaves cfg valid high for a following write
  task automatic write_row(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    if (idx < ROWS)
      check_rows[idx[2:0]] = val;
  endtask

  // all eight rows, then one write past the last row that must be ignored
  task automatic load_rows(row_masks_t masks);
    int r;
    for (r = 0; r < ROWS; r++)
      write_row(CFG_IDX_W'(r), masks[r]);
    write_row(CFG_IDX_W'($urandom_range(15, ROWS)), DATA_W'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  // input side: presents the next queued item, stalls about a quarter of the time
  always @(posedge clk) begin : drive_items
    codec_item_t next_item;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      // item taken at this edge: work out what the block owes for it
      if (in_ch.valid && in_ch.ready)
        awaited_results.insert(awaited_results.size(),
                               coded_result(in_ch.op, in_ch.word_in));
      if (!in_ch.valid || in_ch.ready) begin
        if (queued_words.size() != 0 && (no_stall || $urandom_range(99) >= 25)) begin
          next_item = queued_words.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.op      <= next_item.op;
          in_ch.word_in <= next_item.word;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  // result side: random backpressure, each result checked against the oldest owed
  always @(posedge clk) begin : collect_results
    lbc_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result item arrived with nothing outstanding");
          error_count++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("word_out", want.word_out, out_ch.word_out);
          compare_field("data_out", WORD_W'(want.data_out), WORD_W'(out_ch.data_out));
          compare_field("syndrome", WORD_W'(want.syndrome), WORD_W'(out_ch.syndrome));
          compare_field("status", WORD_W'(want.status), WORD_W'(out_ch.status));
        end
      end
      out_ch.ready <= no_stall || ($urandom_range(99) >= 25);
    end
  end

  // hang detection: any handshake restarts the count
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : run_phases
    row_masks_t masks;
    int         r;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= '0;
    cfg_ch.wdata  <= '0;
    check_rows = ROW_MASK_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset masks: field extremes, clean words, single and double errors
    add_item(OP_ENCODE, 16'h0000);
    add_item(OP_ENCODE, 16'h00FF);
    add_item(OP_ENCODE, 16'hFF5A);                  // high byte must be ignored
    add_item(OP_DECODE, codeword_of(8'hA5));        // clean codeword
    add_item(OP_DECODE, codeword_of(8'h3C) ^ 16'h0010);  // one data bit wrong
    add_item(OP_DECODE, codeword_of(8'h3C) ^ 16'h0400);  // one parity bit wrong
    add_item(OP_DECODE, codeword_of(8'hC3) ^ 16'h0081);  // two bits wrong
    add_item(OP_DECODE, codeword_of(8'h00) ^ 16'h0300);  // two parity bits wrong
    add_item(OP_DECODE, 16'h0000);
    add_item(OP_DECODE, 16'hFFFF);
    add_random_items(90);
    wait_idle;

    // all masks clear: every data column is zero
    masks = '0;
    load_rows(masks);
    add_item(OP_DECODE, 16'h00A5);                  // zero syndrome, nothing flips
    add_item(OP_DECODE, 16'h01A5);                  // hits one parity column
    add_item(OP_DECODE, 16'h03A5);                  // matches no column
    add_item(OP_ENCODE, 16'hFFFF);
    add_random_items(60);
    wait_idle;

    // all masks set: eight equal data columns flip together
    masks = '1;
    load_rows(masks);
    add_item(OP_DECODE, 16'h0001);
    add_item(OP_ENCODE, 16'h0080);
    add_random_items(60);
    wait_idle;

    // random masks, no stalls on either side
    masks = {$urandom, $urandom};
    load_rows(masks);
    no_stall = 1'b1;
    add_random_items(110);
    wait_idle;
    no_stall = 1'b0;

    // data column i equals parity column i, so corrections flip two bits
    for (r = 0; r < ROWS; r++)
      masks[r] = 8'h01 << r;
    load_rows(masks);
    add_random_items(60);
    wait_idle;

    // back to the power-on matrix
    load_rows(ROW_MASK_RESET);
    add_random_items(70);
    wait_idle;

    repeat (8) @(posedge clk);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/lbc_pkg.sv
rtl/core/lbc_ifs.sv
rtl/core/lbc_codec_core.sv
rtl/core/linear_block_codec_16_8.sv
rtl/core/lbc_checker.sv
tb/sv/linear_block_codec_16_8_test.sv
